// ----- design/pfc_pkg.sv -----
`default_nettype none
package pfc_pkg;

  // Layout codes of the src_layout and dst_layout registers.
  localparam logic [1:0] LayMono = 2'd0;
  localparam logic [1:0] LayDual = 2'd1;
  localparam logic [1:0] LayRgb  = 2'd2;

  // Register indexes on the configuration port.
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] RegSrcLayout = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcAlpha  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSrcDepth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDstLayout = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDstAlpha  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDstDepth  = 3'd5;

  // Luma weights in unsigned 0.16 fixed point; they sum to 65536.
  localparam logic [15:0] LumaWr = 16'd19595;
  localparam logic [15:0] LumaWg = 16'd38470;
  localparam logic [15:0] LumaWb = 16'd7471;

  // floor(x / 257) for 16-bit x equals (x * 65281) >> 24.
  localparam logic [15:0] Recip257 = 16'hFF01;

  localparam logic [15:0] Max8  = 16'h00FF;
  localparam logic [15:0] Max16 = 16'hFFFF;

  typedef struct packed {
    logic [1:0] src_layout;
    logic       src_alpha;
    logic       src_depth;
    logic [1:0] dst_layout;
    logic       dst_alpha;
    logic       dst_depth;
  } cfg_t;

  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] a;
  } pix_t;

  typedef struct packed {
    logic [1:0] sl;
    logic [1:0] dl;
    logic       up;
    logic       down;
    logic       unsup;
  } ctrl_t;

  // Layout code three is taken as rgb.
  function automatic logic [1:0] decode_layout(input logic [1:0] code);
    logic [1:0] res;
    res = (code == 2'd3) ? LayRgb : code;
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/pfc_prep.sv -----
`default_nettype none
module pfc_prep (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire pfc_pkg::cfg_t cfg_i,
  input  wire logic [15:0]   comp_first_i,
  input  wire logic [15:0]   comp_second_i,
  input  wire logic [15:0]   comp_third_i,
  input  wire logic [15:0]   alpha_in_i,
  output logic               valid_o,
  output pfc_pkg::pix_t      pix_o,
  output pfc_pkg::ctrl_t     ctrl_o
);

  logic           valid_q;
  pfc_pkg::pix_t  pix_d, pix_q;
  pfc_pkg::ctrl_t ctrl_d, ctrl_q;
  logic [15:0]    c0, c1, c2, a;

  function automatic logic [15:0] clip8(input logic [15:0] v, input logic deep);
    logic [15:0] res;
    res = (!deep && (v > pfc_pkg::Max8)) ? pfc_pkg::Max8 : v;
    return res;
  endfunction

  always_comb begin
    ctrl_d.sl    = pfc_pkg::decode_layout(cfg_i.src_layout);
    ctrl_d.dl    = pfc_pkg::decode_layout(cfg_i.dst_layout);
    ctrl_d.up    = !cfg_i.src_depth && cfg_i.dst_depth;
    ctrl_d.down  = cfg_i.src_depth && !cfg_i.dst_depth;
    ctrl_d.unsup = ((ctrl_d.sl == pfc_pkg::LayMono) && (ctrl_d.dl == pfc_pkg::LayDual)) ||
                   ((ctrl_d.sl == pfc_pkg::LayDual) && (ctrl_d.dl == pfc_pkg::LayMono));

    c0 = clip8(comp_first_i, cfg_i.src_depth);
    c1 = clip8(comp_second_i, cfg_i.src_depth);
    c2 = clip8(comp_third_i, cfg_i.src_depth);
    a  = clip8(alpha_in_i, cfg_i.src_depth);
    if (ctrl_d.sl == pfc_pkg::LayMono) begin
      c1 = '0;
      c2 = '0;
    end
    if (ctrl_d.sl == pfc_pkg::LayDual) begin
      c2 = '0;
    end

    // Alpha is kept, inserted at full scale, or removed.
    if (!cfg_i.dst_alpha) begin
      a = '0;
    end else if (!cfg_i.src_alpha) begin
      a = cfg_i.src_depth ? pfc_pkg::Max16 : pfc_pkg::Max8;
    end

    if (ctrl_d.unsup) begin
      pix_d = '0;
    end else begin
      pix_d.c0 = c0;
      pix_d.c1 = c1;
      pix_d.c2 = c2;
      pix_d.a  = a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    ctrl_q <= ctrl_d;
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign ctrl_o  = ctrl_q;

endmodule
`default_nettype wire

// ----- design/pfc_depth.sv -----
`default_nettype none
module pfc_depth (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire pfc_pkg::pix_t  pix_i,
  input  wire pfc_pkg::ctrl_t ctrl_i,
  output logic                valid_o,
  output pfc_pkg::pix_t       pix_o,
  output pfc_pkg::ctrl_t      ctrl_o
);

  logic           valid_q;
  pfc_pkg::pix_t  pix_d, pix_q;
  pfc_pkg::ctrl_t ctrl_q;

  // An 8-bit value times 257 is the byte written twice; the way down uses
  // a reciprocal multiply, exact for every 16-bit input.
  function automatic logic [15:0] convert(input logic [15:0] v, input logic up,
                                          input logic down);
    logic [31:0] prod;
    logic [15:0] res;
    prod = v * pfc_pkg::Recip257;
    if (up) begin
      res = {v[7:0], v[7:0]};
    end else if (down) begin
      res = {8'd0, prod[31:24]};
    end else begin
      res = v;
    end
    return res;
  endfunction

  always_comb begin
    pix_d.c0 = convert(pix_i.c0, ctrl_i.up, ctrl_i.down);
    pix_d.c1 = convert(pix_i.c1, ctrl_i.up, ctrl_i.down);
    pix_d.c2 = convert(pix_i.c2, ctrl_i.up, ctrl_i.down);
    pix_d.a  = convert(pix_i.a, ctrl_i.up, ctrl_i.down);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    ctrl_q <= ctrl_i;
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign ctrl_o  = ctrl_q;

endmodule
`default_nettype wire

// ----- design/pfc_layout.sv -----
`default_nettype none
module pfc_layout (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire pfc_pkg::pix_t  pix_i,
  input  wire pfc_pkg::ctrl_t ctrl_i,
  output logic                valid_o,
  output pfc_pkg::pix_t       pix_o,
  output logic                unsup_o
);

  // First half: the three luma products.
  logic           prod_valid_q;
  pfc_pkg::pix_t  prod_pix_q;
  pfc_pkg::ctrl_t prod_ctrl_q;
  logic [31:0]    pr_d, pg_d, pb_d;
  logic [31:0]    pr_q, pg_q, pb_q;

  // Second half: sum and layout selection into the output register.
  logic           out_valid_q;
  pfc_pkg::pix_t  out_pix_d, out_pix_q;
  logic           out_unsup_q;
  logic [31:0]    luma_sum;

  always_comb begin
    pr_d = pix_i.c0 * pfc_pkg::LumaWr;
    pg_d = pix_i.c1 * pfc_pkg::LumaWg;
    pb_d = pix_i.c2 * pfc_pkg::LumaWb;
  end

  always_comb begin
    // The weights sum to 65536, so the sum never exceeds 32 bits.
    luma_sum  = pr_q + pg_q + pb_q;
    out_pix_d = prod_pix_q;
    if ((prod_ctrl_q.sl == pfc_pkg::LayRgb) && (prod_ctrl_q.dl == pfc_pkg::LayMono)) begin
      out_pix_d.c0 = luma_sum[31:16];
      out_pix_d.c1 = '0;
      out_pix_d.c2 = '0;
    end else if ((prod_ctrl_q.sl == pfc_pkg::LayMono) &&
                 (prod_ctrl_q.dl == pfc_pkg::LayRgb)) begin
      out_pix_d.c1 = prod_pix_q.c0;
      out_pix_d.c2 = prod_pix_q.c0;
    end else if ((prod_ctrl_q.sl == pfc_pkg::LayDual) &&
                 (prod_ctrl_q.dl == pfc_pkg::LayRgb)) begin
      out_pix_d.c2 = '0;
    end else if ((prod_ctrl_q.sl == pfc_pkg::LayRgb) &&
                 (prod_ctrl_q.dl == pfc_pkg::LayDual)) begin
      out_pix_d.c2 = '0;
      out_pix_d.a  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q        <= pr_d;
    pg_q        <= pg_d;
    pb_q        <= pb_d;
    prod_pix_q  <= pix_i;
    prod_ctrl_q <= ctrl_i;
    out_pix_q   <= out_pix_d;
    out_unsup_q <= prod_ctrl_q.unsup;
  end

  assign valid_o = out_valid_q;
  assign pix_o   = out_pix_q;
  assign unsup_o = out_unsup_q;

endmodule
`default_nettype wire

// ----- design/pixel_format_converter.sv -----
`default_nettype none
// Pixel format converter: one pixel in, one converted pixel out, every clock
// cycle. A transaction starts when start_i is high and busy_o is low; busy_o
// is always low, so a pixel may be offered in every cycle. The converted pixel
// appears on the result ports, marked by done_o for exactly one cycle. The
// receiver cannot stall the block and must take every result in the cycle
// it is shown. The pipeline holds input preparation (clipping, layout
// masking and the alpha step), the depth step (byte duplication for 8 to
// 16 bits, a reciprocal multiply for 16 to 8 bits), the luma products, and
// the luma sum with the layout step into the output register. Configuration
// registers are written through cfg_we_i, cfg_idx_i and cfg_data_i and take
// effect at once; write them only while no pixel is in flight. Mono to dual
// and dual to mono requests raise unsupported_o and return an all-zero pixel.
module pixel_format_converter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [15:0]                  comp_first_i,
  input  wire logic [15:0]                  comp_second_i,
  input  wire logic [15:0]                  comp_third_i,
  input  wire logic [15:0]                  alpha_in_i,
  output logic                              done_o,
  output logic [15:0]                       out_first_o,
  output logic [15:0]                       out_second_o,
  output logic [15:0]                       out_third_o,
  output logic [15:0]                       alpha_out_o,
  output logic                              unsupported_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [pfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pfc_pkg::CfgDataW-1:0] cfg_data_i
);

  pfc_pkg::cfg_t  cfg_d, cfg_q;
  logic           accept;

  logic           s1_valid, s2_valid, s3_valid;
  pfc_pkg::pix_t  s1_pix, s2_pix, s3_pix;
  pfc_pkg::ctrl_t s1_ctrl, s2_ctrl;
  logic           s3_unsup;

  // Every stage advances in every cycle, so the block is never busy.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Writes to indexes past the last register are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pfc_pkg::RegSrcLayout: cfg_d.src_layout = cfg_data_i;
        pfc_pkg::RegSrcAlpha:  cfg_d.src_alpha  = cfg_data_i[0];
        pfc_pkg::RegSrcDepth:  cfg_d.src_depth  = cfg_data_i[0];
        pfc_pkg::RegDstLayout: cfg_d.dst_layout = cfg_data_i;
        pfc_pkg::RegDstAlpha:  cfg_d.dst_alpha  = cfg_data_i[0];
        pfc_pkg::RegDstDepth:  cfg_d.dst_depth  = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_layout <= pfc_pkg::LayRgb;
      cfg_q.src_alpha  <= 1'b0;
      cfg_q.src_depth  <= 1'b0;
      cfg_q.dst_layout <= pfc_pkg::LayRgb;
      cfg_q.dst_alpha  <= 1'b0;
      cfg_q.dst_depth  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pfc_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .cfg_i         (cfg_q),
    .comp_first_i  (comp_first_i),
    .comp_second_i (comp_second_i),
    .comp_third_i  (comp_third_i),
    .alpha_in_i    (alpha_in_i),
    .valid_o       (s1_valid),
    .pix_o         (s1_pix),
    .ctrl_o        (s1_ctrl)
  );

  pfc_depth u_depth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .pix_i   (s1_pix),
    .ctrl_i  (s1_ctrl),
    .valid_o (s2_valid),
    .pix_o   (s2_pix),
    .ctrl_o  (s2_ctrl)
  );

  pfc_layout u_layout (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .pix_i   (s2_pix),
    .ctrl_i  (s2_ctrl),
    .valid_o (s3_valid),
    .pix_o   (s3_pix),
    .unsup_o (s3_unsup)
  );

  assign done_o        = s3_valid;
  assign out_first_o   = s3_pix.c0;
  assign out_second_o  = s3_pix.c1;
  assign out_third_o   = s3_pix.c2;
  assign alpha_out_o   = s3_pix.a;
  assign unsupported_o = s3_unsup;

endmodule
`default_nettype wire

// ----- tb/sv/pfc_checker.sv -----
`timescale 1ns / 1ps
module pfc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_o,
  input  logic [15:0]                  comp_first_i,
  input  logic [15:0]                  comp_second_i,
  input  logic [15:0]                  comp_third_i,
  input  logic [15:0]                  alpha_in_i,
  input  logic                         done_o,
  input  logic [15:0]                  out_first_o,
  input  logic [15:0]                  out_second_o,
  input  logic [15:0]                  out_third_o,
  input  logic [15:0]                  alpha_out_o,
  input  logic                         unsupported_o,
  input  logic                         cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           mismatch_count_o,
  output int                           pending_count_o
);

  localparam logic [31:0] Scale257 = 32'h0000_0101;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] third;
    logic [15:0] alpha;
    logic        unsup;
  } pixel_out_t;

  pfc_pkg::cfg_t format_cfg;
  pixel_out_t    expected_pixels[$];
  pixel_out_t    want;
  pixel_out_t    got;

  function automatic logic [31:0] clip_to_8(input logic [31:0] v);
    return (v > 32'(pfc_pkg::Max8)) ? 32'(pfc_pkg::Max8) : v;
  endfunction

  // Alpha step at source depth, then depth step, then layout step.
  function automatic pixel_out_t convert_pixel(input pfc_pkg::cfg_t cfg,
                                               input logic [15:0] r_in,
                                               input logic [15:0] g_in,
                                               input logic [15:0] b_in,
                                               input logic [15:0] a_in);
    pixel_out_t  res;
    logic [1:0]  sl;
    logic [1:0]  dl;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] al;
    logic [47:0] luma;
    logic        with_alpha;
    res = '0;
    // The unused fourth layout code behaves as rgb.
    sl = (&cfg.src_layout) ? pfc_pkg::LayRgb : cfg.src_layout;
    dl = (&cfg.dst_layout) ? pfc_pkg::LayRgb : cfg.dst_layout;
    if ((sl == pfc_pkg::LayMono && dl == pfc_pkg::LayDual) ||
        (sl == pfc_pkg::LayDual && dl == pfc_pkg::LayMono)) begin
      res.unsup = 1'b1;
      return res;
    end
    c0 = 32'(r_in);
    c1 = 32'(g_in);
    c2 = 32'(b_in);
    al = 32'(a_in);
    if (!cfg.src_depth) begin
      c0 = clip_to_8(c0);
      c1 = clip_to_8(c1);
      c2 = clip_to_8(c2);
      al = clip_to_8(al);
    end
    if (sl == pfc_pkg::LayMono) begin
      c1 = '0;
      c2 = '0;
    end
    if (sl == pfc_pkg::LayDual) c2 = '0;
    with_alpha = cfg.src_alpha;
    if (!with_alpha) al = '0;
    if (cfg.dst_alpha && !with_alpha) begin
      al = cfg.src_depth ? 32'(pfc_pkg::Max16) : 32'(pfc_pkg::Max8);
    end else if (!cfg.dst_alpha && with_alpha) begin
      al = '0;
    end
    if (!cfg.src_depth && cfg.dst_depth) begin
      c0 = c0 * Scale257;
      c1 = c1 * Scale257;
      c2 = c2 * Scale257;
      al = al * Scale257;
    end else if (cfg.src_depth && !cfg.dst_depth) begin
      c0 = c0 / Scale257;
      c1 = c1 / Scale257;
      c2 = c2 / Scale257;
      al = al / Scale257;
    end
    if (sl == pfc_pkg::LayRgb && dl == pfc_pkg::LayMono) begin
      luma = 48'(pfc_pkg::LumaWr) * 48'(c0) + 48'(pfc_pkg::LumaWg) * 48'(c1) +
             48'(pfc_pkg::LumaWb) * 48'(c2);
      c0 = 32'(luma >> 16);
      c1 = '0;
      c2 = '0;
    end else if (sl == pfc_pkg::LayMono && dl == pfc_pkg::LayRgb) begin
      c1 = c0;
      c2 = c0;
    end else if (sl == pfc_pkg::LayDual && dl == pfc_pkg::LayRgb) begin
      c2 = '0;
    end else if (sl == pfc_pkg::LayRgb && dl == pfc_pkg::LayDual) begin
      c2 = '0;
      al = '0;
    end
    res.first  = c0[15:0];
    res.second = c1[15:0];
    res.third  = c2[15:0];
    res.alpha  = al[15:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_cfg.src_layout = pfc_pkg::LayRgb;
      format_cfg.src_alpha  = 1'b0;
      format_cfg.src_depth  = 1'b0;
      format_cfg.dst_layout = pfc_pkg::LayRgb;
      format_cfg.dst_alpha  = 1'b0;
      format_cfg.dst_depth  = 1'b0;
      expected_pixels.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfc_pkg::RegSrcLayout: format_cfg.src_layout = cfg_data_i[1:0];
          pfc_pkg::RegSrcAlpha:  format_cfg.src_alpha  = cfg_data_i[0];
          pfc_pkg::RegSrcDepth:  format_cfg.src_depth  = cfg_data_i[0];
          pfc_pkg::RegDstLayout: format_cfg.dst_layout = cfg_data_i[1:0];
          pfc_pkg::RegDstAlpha:  format_cfg.dst_alpha  = cfg_data_i[0];
          pfc_pkg::RegDstDepth:  format_cfg.dst_depth  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        expected_pixels.push_back(convert_pixel(format_cfg, comp_first_i, comp_second_i,
                                                comp_third_i, alpha_in_i));
      end
      if (done_o) begin
        got = {out_first_o, out_second_o, out_third_o, alpha_out_o, unsupported_o};
        if (expected_pixels.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: result with no transaction pending: %h %h %h a=%h u=%b",
                     $realtime, got.first, got.second, got.third, got.alpha, got.unsup);
          end
          mismatch_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (mismatch_count_o < 10) begin
              $display({"%0t: pixel mismatch: expected %h %h %h a=%h u=%b, ",
                        "got %h %h %h a=%h u=%b"},
                       $realtime, want.first, want.second, want.third, want.alpha,
                       want.unsup, got.first, got.second, got.third, got.alpha,
                       got.unsup);
            end
            mismatch_count_o++;
          end
        end
      end
      pending_count_o = expected_pixels.size();
    end
  end

endmodule

// ----- tb/sv/pixel_format_converter_tb.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the pixel format converter. The checker beside the
// block watches every transaction and predicts the converted pixel; this
// module only drives pixels and format settings and reports the outcome.
module pixel_format_converter_tb;

  // How often the pixel source pauses between transactions.
  typedef enum int {
    IdleNone,
    IdleHeavy,
    IdleLight
  } idle_mode_t;

  localparam int RandomPixels = 800;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [15:0]                  comp_first_i;
  logic [15:0]                  comp_second_i;
  logic [15:0]                  comp_third_i;
  logic [15:0]                  alpha_in_i;
  logic                         done_o;
  logic [15:0]                  out_first_o;
  logic [15:0]                  out_second_o;
  logic [15:0]                  out_third_o;
  logic [15:0]                  alpha_out_o;
  logic                         unsupported_o;
  logic                         cfg_we_i;
  logic [pfc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pfc_pkg::CfgDataW-1:0] cfg_data_i;
  int                           mismatch_count;
  int                           pending_count;

  int         pixels_sent;
  int         phase_pixels;
  int         phase;
  idle_mode_t idle_mode;

  pixel_format_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .comp_first_i  (comp_first_i),
    .comp_second_i (comp_second_i),
    .comp_third_i  (comp_third_i),
    .alpha_in_i    (alpha_in_i),
    .done_o        (done_o),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o),
    .out_third_o   (out_third_o),
    .alpha_out_o   (alpha_out_o),
    .unsupported_o (unsupported_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  pfc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .comp_first_i     (comp_first_i),
    .comp_second_i    (comp_second_i),
    .comp_third_i     (comp_third_i),
    .alpha_in_i       (alpha_in_i),
    .done_o           (done_o),
    .out_first_o      (out_first_o),
    .out_second_o     (out_second_o),
    .out_third_o      (out_third_o),
    .alpha_out_o      (alpha_out_o),
    .unsupported_o    (unsupported_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs or never answers. The limit leaves a
  // wide margin over the slowest correct run.
  initial begin
    #2_000_000;
    $display("** pixel_format_converter: FAILED **");
    $finish;
  end

  // Component values lean toward the corners: zero, full scale at either
  // depth and the first value past the 8-bit range. The rest is uniform over
  // the 8-bit range or the whole 16 bits, so every bit sees both values and
  // 8-bit sources see plenty of overrange input.
  function automatic logic [15:0] rand_component();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = 16'h00FF;
      3: v = 16'h0100;
      4, 5: v = 16'($urandom_range(0, 255));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Offers one pixel, starting and ending at a falling edge. start_i is left
  // high, so back-to-back transactions keep it high without a glitch.
  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic [15:0] a,
                            input idle_mode_t mode);
    int pause_pct;
    pause_pct = (mode == IdleHeavy) ? 87 : (mode == IdleLight) ? 10 : 0;
    while ($urandom_range(0, 99) < pause_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    comp_first_i  <= r;
    comp_second_i <= g;
    comp_third_i  <= b;
    alpha_in_i    <= a;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  // Stops the pixel stream and waits until every converted pixel has come
  // back, then waits on with a margin for the four-stage pipeline.
  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [pfc_pkg::CfgIdxW-1:0] idx,
                           input logic [pfc_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // Registers only change while the pipeline is empty. The single-bit flags
  // get the full two-bit data word so the unused upper bit is exercised.
  task automatic set_format(input logic [1:0] sl, input logic [1:0] sa, input logic [1:0] sd,
                            input logic [1:0] dl, input logic [1:0] da, input logic [1:0] dd);
    drain_pipeline();
    write_reg(pfc_pkg::RegSrcLayout, sl);
    write_reg(pfc_pkg::RegSrcAlpha, sa);
    write_reg(pfc_pkg::RegSrcDepth, sd);
    write_reg(pfc_pkg::RegDstLayout, dl);
    write_reg(pfc_pkg::RegDstAlpha, da);
    write_reg(pfc_pkg::RegDstDepth, dd);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    comp_first_i  = '0;
    comp_second_i = '0;
    comp_third_i  = '0;
    alpha_in_i    = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    pixels_sent   = 0;
    // Reset is held across rising clock edges and released at a falling edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset format is 8-bit rgb to 8-bit rgb: zero, overrange clipping on
    // every field, and an ordinary pixel whose alpha must be dropped.
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, IdleNone);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, IdleNone);
    send_pixel(16'h00FF, 16'h0080, 16'h0001, 16'h004D, IdleNone);

    // Layout code three as source, 16-bit with alpha down to 8-bit rgb with
    // alpha; the division by 257 truncates.
    set_format(2'd3, 2'd1, 2'd1, pfc_pkg::LayRgb, 2'd1, 2'd0);
    send_pixel(16'hFFFF, 16'h8080, 16'h0101, 16'hFFFF, IdleNone);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, IdleNone);

    // Luma at 16 bits, with full-scale alpha inserted.
    set_format(pfc_pkg::LayRgb, 2'd0, 2'd1, pfc_pkg::LayMono, 2'd1, 2'd1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, IdleNone);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h1111, IdleNone);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h2222, IdleNone);

    // Mono replicated into rgb (code three as destination), 8 to 16 bits,
    // alpha inserted at 8-bit full scale before the widening. The unused
    // green and blue inputs carry junk.
    set_format(pfc_pkg::LayMono, 2'd0, 2'd0, 2'd3, 2'd1, 2'd1);
    send_pixel(16'h00FF, 16'h1234, 16'h5678, 16'h0009, IdleNone);
    send_pixel(16'h0100, 16'hFFFF, 16'hFFFF, 16'hFFFF, IdleNone);

    // Dual into rgb leaves blue at zero; source alpha is removed.
    set_format(pfc_pkg::LayDual, 2'd1, 2'd0, pfc_pkg::LayRgb, 2'd0, 2'd1);
    send_pixel(16'h00AB, 16'h00CD, 16'h00EF, 16'h0012, IdleNone);

    // Rgb into dual drops alpha even though the destination asks for it.
    set_format(pfc_pkg::LayRgb, 2'd1, 2'd1, pfc_pkg::LayDual, 2'd1, 2'd1);
    send_pixel(16'h1111, 16'h2222, 16'h3333, 16'h4444, IdleNone);

    // Mono and dual pairs in both directions are flagged with a zero pixel.
    set_format(pfc_pkg::LayMono, 2'd0, 2'd0, pfc_pkg::LayDual, 2'd0, 2'd0);
    send_pixel(16'h0005, 16'h0006, 16'h0007, 16'h0008, IdleNone);
    set_format(pfc_pkg::LayDual, 2'd1, 2'd1, pfc_pkg::LayMono, 2'd1, 2'd1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, IdleNone);

    // Same layout passes through; 16 to 8 bits around the 257 boundaries.
    set_format(pfc_pkg::LayDual, 2'd1, 2'd1, pfc_pkg::LayDual, 2'd1, 2'd0);
    send_pixel(16'hFFFF, 16'hFEFF, 16'h0100, 16'h0101, IdleNone);
    send_pixel(16'h0100, 16'h0000, 16'hFFFF, 16'hFEFE, IdleNone);

    // Random part: each phase picks a format, a source idle pattern and a
    // burst length. The first two phases pin every register to its lowest
    // and highest code.
    pixels_sent = 0;
    phase       = 0;
    while (pixels_sent < RandomPixels) begin
      if (phase == 0) begin
        set_format(2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0);
      end else if (phase == 1) begin
        set_format(2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3);
      end else begin
        set_format(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
      idle_mode    = idle_mode_t'(phase % 3);
      phase_pixels = $urandom_range(10, 40);
      repeat (phase_pixels) begin
        send_pixel(rand_component(), rand_component(), rand_component(), rand_component(),
                   idle_mode);
      end
      phase++;
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("** pixel_format_converter: PASSED **");
    end else begin
      $display("** pixel_format_converter: FAILED **");
    end
    $finish;
  end

endmodule
